### hdl/ltdf_pkg.sv
// Package for the location table duplicate filter.
// Types, codes and defaults shared by ltdf_cell and the top level.
`timescale 1ns / 1ps
package ltdf_pkg;
    localparam int unsigned ENTRIES_DEF    = 16;
    localparam int unsigned SEQ_BITS_DEF   = 16;
    localparam int unsigned STAMP_BITS_DEF = 32;
    localparam int unsigned IDX_MAX_W      = 8;
    localparam int unsigned CNT_MAX_W      = 9;
    localparam logic [15:0] LIFE_RESET     = 16'd20;

    localparam logic [1:0] CFG_LOCAL_ADDR = 2'd0;
    localparam logic [1:0] CFG_LIFETIME   = 2'd1;

    localparam logic [2:0] ST_NEW  = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_DUP  = 3'd2;
    localparam logic [2:0] ST_OWN  = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_TICK = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    // scan token handed from cell to cell
    typedef struct packed {
        logic                 active;
        logic                 tick;
        logic                 hit;
        logic [IDX_MAX_W-1:0] hit_idx;
        logic [31:0]          hit_ts;
        logic [15:0]          hit_seq;
        logic                 hit_nb;
        logic                 free;
        logic [IDX_MAX_W-1:0] free_idx;
        logic [CNT_MAX_W-1:0] cnt;
    } t_carry;

    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] idx;
        logic                 alloc;
        logic                 wr_seq;
        logic                 wr_pv;
        logic                 nb;
        logic [31:0]          ts;
        logic [15:0]          seq;
        logic [31:0]          lat;
        logic [31:0]          lon;
        logic [15:0]          life;
    } t_wr;

    function automatic logic newer(logic [31:0] a, logic [31:0] b, int unsigned bits);
        logic [31:0] h;
        h = 32'(((64'd1 << bits) - 64'd1) >> 1);
        return ((a > b) && ((a - b) <= h)) || ((b > a) && ((b - a) > h));
    endfunction
endpackage

### hdl/ltdf_cell.sv
// One table slot of the location table with its stage of the scan chain.
// Depends on ltdf_pkg.
`timescale 1ns / 1ps
module ltdf_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ltdf_pkg::t_carry i_carry,
    output ltdf_pkg::t_carry o_carry,
    input  logic [47:0]      i_mac,
    input  ltdf_pkg::t_wr    i_wr
);
    logic             r_valid, n_valid;
    logic [47:0]      r_addr;
    logic [31:0]      r_ts, r_lat, r_lon;
    logic [15:0]      r_seq, r_life, n_life;
    logic             r_nb;
    ltdf_pkg::t_carry r_carry, n_carry;
    logic             wr_hit;

    assign wr_hit = i_wr.en && (i_wr.idx == ltdf_pkg::IDX_MAX_W'(IDX));

    always_comb begin
        n_carry = i_carry;
        n_valid = r_valid;
        n_life  = r_life;
        if (i_carry.active) begin
            if (i_carry.tick) begin
                if (r_valid) begin
                    if (r_life <= 16'd1) begin
                        n_valid     = 1'b0;
                        n_carry.cnt = i_carry.cnt + 1'b1;
                    end else begin
                        n_life = r_life - 16'd1;
                    end
                end
            end else begin
                if (r_valid && r_addr == i_mac && !i_carry.hit) begin
                    n_carry.hit     = 1'b1;
                    n_carry.hit_idx = ltdf_pkg::IDX_MAX_W'(IDX);
                    n_carry.hit_ts  = r_ts;
                    n_carry.hit_seq = r_seq;
                    n_carry.hit_nb  = r_nb;
                end
                if (!r_valid && !i_carry.free) begin
                    n_carry.free     = 1'b1;
                    n_carry.free_idx = ltdf_pkg::IDX_MAX_W'(IDX);
                end
            end
        end
        if (wr_hit) begin
            n_life = i_wr.life;
            if (i_wr.alloc) begin
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_carry.active <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_carry <= n_carry;
            r_life  <= n_life;
            if (wr_hit) begin
                r_nb <= i_wr.nb;
                if (i_wr.alloc) begin
                    r_addr <= i_mac;
                end
                if (i_wr.alloc || i_wr.wr_seq) begin
                    r_seq <= i_wr.seq;
                end
                if (i_wr.alloc || i_wr.wr_pv) begin
                    r_ts  <= i_wr.ts;
                    r_lat <= i_wr.lat;
                    r_lon <= i_wr.lon;
                end
            end
        end
    end

    assign o_carry = r_carry;
endmodule

### hdl/location_table_duplicate_filter.sv
// Top level of the location table duplicate filter: control, config, result.
// Depends on ltdf_pkg and ltdf_cell.
//
// Usage:
// Input items (i_valid / o_stall) are packets (i_req_type 0) or lifetime
// ticks (i_req_type 1). Each item gives one result on o_valid / i_stall.
// An accepted item sends a token down the row of ENTRIES slot cells, one
// cell per cycle; a packet looks up or allocates its source, a tick ages
// every slot on the way. The decide state then registers the result and
// its table write-back together. One item is worked on at a time; the
// next is taken the cycle after the result is registered, even while
// that result waits.
// When the receiver stalls with a result pending, the block holds the next
// finished result and its table write until the output register frees.
// Reset empties the table, sets the local address to 0 and the lifetime
// to 20 ticks. Config writes (i_cfg_valid / o_cfg_ready) are always taken.
`timescale 1ns / 1ps
module location_table_duplicate_filter #(
    parameter int unsigned ENTRIES    = ltdf_pkg::ENTRIES_DEF,
    parameter int unsigned SEQ_BITS   = ltdf_pkg::SEQ_BITS_DEF,
    parameter int unsigned STAMP_BITS = ltdf_pkg::STAMP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [2:0]  i_pkt_kind,
    input  logic [47:0] i_src_mac,
    input  logic [31:0] i_timestamp,
    input  logic [15:0] i_seq_num,
    input  logic signed [31:0] i_latitude,
    input  logic signed [31:0] i_longitude,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_entry_index,
    output logic        o_is_neighbour,
    output logic        o_pv_updated,
    output logic [4:0]  o_expired_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    localparam logic [31:0] TS_MASK  = 32'((64'd1 << STAMP_BITS) - 64'd1);
    localparam logic [15:0] SEQ_MASK = 16'((64'd1 << SEQ_BITS) - 64'd1);

    ltdf_pkg::t_state r_state, n_state;
    logic [47:0] r_local;
    logic [15:0] r_life_cfg;
    logic        r_req, r_single;
    logic [47:0] r_mac;
    logic [31:0] r_ts, r_lat, r_lon;
    logic [15:0] r_seq;
    logic        r_inj;
    ltdf_pkg::t_carry r_res;
    ltdf_pkg::t_carry chain [ENTRIES+1];
    ltdf_pkg::t_wr    r_wr, d_wr;
    logic        r_ovalid;
    logic [2:0]  r_status, d_status;
    logic [3:0]  r_idx, d_idx;
    logic        r_nb, d_nb, r_pv, d_pv;
    logic [4:0]  r_cnt, d_cnt;
    logic        in_acc, out_free, capture, issue;
    logic        ts_new, seq_new, accept;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        chain[0]        = '0;
        chain[0].active = r_inj;
        chain[0].tick   = r_req;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ltdf_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_carry (chain[g]),
            .o_carry (chain[g+1]),
            .i_mac   (r_mac),
            .i_wr    (r_wr)
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltdf_pkg::S_IDLE:   if (i_valid) n_state = ltdf_pkg::S_SCAN;
            ltdf_pkg::S_SCAN:   if (chain[ENTRIES].active) n_state = ltdf_pkg::S_DECIDE;
            ltdf_pkg::S_DECIDE: if (out_free) n_state = ltdf_pkg::S_IDLE;
            default:            n_state = ltdf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ltdf_pkg::S_IDLE);
        capture = (r_state == ltdf_pkg::S_SCAN) && chain[ENTRIES].active;
        issue   = (r_state == ltdf_pkg::S_DECIDE) && out_free;
    end

    always_comb begin
        ts_new  = ltdf_pkg::newer(r_ts, r_res.hit_ts, STAMP_BITS);
        seq_new = ltdf_pkg::newer({16'd0, r_seq}, {16'd0, r_res.hit_seq}, SEQ_BITS);
        accept  = ts_new || (!r_single && (r_ts == r_res.hit_ts) && seq_new);
        d_wr        = '0;
        d_wr.idx    = r_res.hit_idx;
        d_wr.nb     = r_single;
        d_wr.ts     = r_ts;
        d_wr.seq    = r_seq;
        d_wr.lat    = r_lat;
        d_wr.lon    = r_lon;
        d_wr.life   = r_life_cfg;
        d_status    = ltdf_pkg::ST_TICK;
        d_idx       = 4'd0;
        d_nb        = 1'b0;
        d_pv        = 1'b0;
        d_cnt       = 5'(r_res.cnt);
        if (!r_req) begin
            d_cnt = 5'd0;
            priority if (r_mac == r_local) begin
                d_status = ltdf_pkg::ST_OWN;
            end else if (!r_res.hit) begin
                if (!r_res.free) begin
                    d_status = ltdf_pkg::ST_FULL;
                end else begin
                    d_status   = ltdf_pkg::ST_NEW;
                    d_wr.en    = 1'b1;
                    d_wr.alloc = 1'b1;
                    d_wr.idx   = r_res.free_idx;
                    d_idx      = 4'(r_res.free_idx);
                    d_nb       = r_single;
                    d_pv       = 1'b1;
                end
            end else if (!accept) begin
                d_status = ltdf_pkg::ST_DUP;
                d_idx    = 4'(r_res.hit_idx);
                d_nb     = r_res.hit_nb;
            end else begin
                d_status    = ltdf_pkg::ST_UPD;
                d_wr.en     = 1'b1;
                d_wr.wr_seq = !r_single;
                d_wr.wr_pv  = ts_new;
                d_idx       = 4'(r_res.hit_idx);
                d_nb        = r_single;
                d_pv        = ts_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ltdf_pkg::S_IDLE;
            r_inj      <= 1'b0;
            r_wr.en    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_local    <= 48'd0;
            r_life_cfg <= ltdf_pkg::LIFE_RESET;
        end else begin
            r_state <= n_state;
            r_inj   <= in_acc;
            r_wr.en <= issue && d_wr.en;
            if (issue) begin
                r_ovalid    <= 1'b1;
                r_wr.idx    <= d_wr.idx;
                r_wr.alloc  <= d_wr.alloc;
                r_wr.wr_seq <= d_wr.wr_seq;
                r_wr.wr_pv  <= d_wr.wr_pv;
                r_wr.nb     <= d_wr.nb;
                r_wr.ts     <= d_wr.ts;
                r_wr.seq    <= d_wr.seq;
                r_wr.lat    <= d_wr.lat;
                r_wr.lon    <= d_wr.lon;
                r_wr.life   <= d_wr.life;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ltdf_pkg::CFG_LOCAL_ADDR: r_local    <= i_cfg_data;
                    ltdf_pkg::CFG_LIFETIME:   r_life_cfg <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req    <= i_req_type;
            r_single <= (i_pkt_kind <= 3'd1);
            r_mac    <= i_src_mac;
            r_ts     <= i_timestamp & TS_MASK;
            r_seq    <= i_seq_num & SEQ_MASK;
            r_lat    <= i_latitude;
            r_lon    <= i_longitude;
        end
        if (capture) begin
            r_res <= chain[ENTRIES];
        end
        if (issue) begin
            r_status    <= d_status;
            r_idx       <= d_idx;
            r_nb        <= d_nb;
            r_pv        <= d_pv;
            r_cnt       <= d_cnt;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_entry_index   = r_idx;
    assign o_is_neighbour  = r_nb;
    assign o_pv_updated    = r_pv;
    assign o_expired_count = r_cnt;
    assign o_cfg_ready     = 1'b1;
endmodule

### verif/location_table_duplicate_filter_tb.sv
// Testbench for location_table_duplicate_filter: random and directed packets
// and ticks, checked against a table model kept in a scoreboard class.
// Depends on ltdf_pkg and the location_table_duplicate_filter RTL.
`timescale 1ns / 1ps
module location_table_duplicate_filter_tb;

    localparam int NSLOT = 16;
    localparam int LAT   = 40;
    localparam longint LIMIT = 600000;

    typedef struct packed {
        logic        req;
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [31:0] ts;
        logic [15:0] sn;
        logic [31:0] lat;
        logic [31:0] lon;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] idx;
        logic       nb;
        logic       pv;
        logic [4:0] cnt;
    } t_verdict;

    class table_scoreboard;
        bit          used[NSLOT];
        logic [47:0] addr[NSLOT];
        logic [31:0] stamp[NSLOT];
        logic [15:0] seqn[NSLOT];
        logic [31:0] plat[NSLOT];
        logic [31:0] plon[NSLOT];
        bit          nbr[NSLOT];
        logic [15:0] life[NSLOT];
        logic [47:0] own_addr = '0;
        logic [15:0] life_load = ltdf_pkg::LIFE_RESET;
        t_verdict    pending[$];
        int          errors = 0;
        int          checked = 0;
        int          stat_seen[8];

        function bit fresher(logic [31:0] a, logic [31:0] b, logic [31:0] h);
            return ((a > b) && ((a - b) <= h)) || ((b > a) && ((b - a) > h));
        endfunction

        function void note_item(t_item it);
            t_verdict v;
            int hit, fr, cnt;
            bit single, tn, ok;
            v = '0;
            hit = -1;
            fr = -1;
            cnt = 0;
            single = (it.kind <= 1);
            if (it.req) begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (used[i]) begin
                        if (life[i] <= 1) begin
                            used[i] = 0;
                            cnt++;
                        end else life[i]--;
                    end
                end
                v.status = ltdf_pkg::ST_TICK;
                v.cnt = cnt[4:0];
            end else if (it.mac == own_addr) begin
                v.status = ltdf_pkg::ST_OWN;
            end else begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (used[i] && addr[i] == it.mac && hit < 0) hit = i;
                    if (!used[i] && fr < 0) fr = i;
                end
                if (hit < 0) begin
                    if (fr < 0) v.status = ltdf_pkg::ST_FULL;
                    else begin
                        used[fr] = 1;
                        addr[fr] = it.mac;
                        stamp[fr] = it.ts;
                        seqn[fr] = it.sn;
                        plat[fr] = it.lat;
                        plon[fr] = it.lon;
                        nbr[fr] = single;
                        life[fr] = life_load;
                        v.status = ltdf_pkg::ST_NEW;
                        v.idx = fr[3:0];
                        v.nb = single;
                        v.pv = 1;
                    end
                end else begin
                    tn = fresher(it.ts, stamp[hit], 32'h7fffffff);
                    ok = tn || (!single && it.ts == stamp[hit]
                                && fresher({16'h0, it.sn}, {16'h0, seqn[hit]}, 32'h7fff));
                    v.idx = hit[3:0];
                    if (!ok) begin
                        v.status = ltdf_pkg::ST_DUP;
                        v.nb = nbr[hit];
                    end else begin
                        if (!single) seqn[hit] = it.sn;
                        if (tn) begin
                            stamp[hit] = it.ts;
                            plat[hit] = it.lat;
                            plon[hit] = it.lon;
                        end
                        nbr[hit] = single;
                        life[hit] = life_load;
                        v.status = ltdf_pkg::ST_UPD;
                        v.nb = single;
                        v.pv = tn;
                    end
                end
            end
            pending.push_back(v);
        endfunction

        function void check_result(t_verdict got);
            t_verdict want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            stat_seen[want.status]++;
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_req_type = 0;
    logic [2:0]  i_pkt_kind = 0;
    logic [47:0] i_src_mac = 0;
    logic [31:0] i_timestamp = 0;
    logic [15:0] i_seq_num = 0;
    logic signed [31:0] i_latitude = 0;
    logic signed [31:0] i_longitude = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [2:0]  o_status;
    logic [3:0]  o_entry_index;
    logic        o_is_neighbour;
    logic        o_pv_updated;
    logic [4:0]  o_expired_count;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [47:0] i_cfg_data = 0;

    location_table_duplicate_filter dut (.*);

    always #6 i_clk = ~i_clk;

    table_scoreboard sb = new();
    longint cycles = 0;
    int     sent = 0;
    int     rx_wait = 0;
    bit     hold_off = 0;
    logic [47:0] macs[24];

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("location_table_duplicate_filter_tb: errors");
            $finish;
        end
    end

    // result side: random wait per item, plus a long hold when requested
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_status, o_entry_index, o_is_neighbour,
                             o_pv_updated, o_expired_count});
            rx_wait = $urandom_range(0, 6);
        end
        if (hold_off) i_stall <= 1;
        else if (rx_wait > 0) begin
            i_stall <= 1;
            if (o_valid && i_stall) rx_wait--;
        end else i_stall <= 0;
    end

    task automatic send(t_item it, int gap);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1;
        i_req_type  <= it.req;
        i_pkt_kind  <= it.kind;
        i_src_mac   <= it.mac;
        i_timestamp <= it.ts;
        i_seq_num   <= it.sn;
        i_latitude  <= it.lat;
        i_longitude <= it.lon;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(it);
        sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        if (idx == ltdf_pkg::CFG_LOCAL_ADDR) sb.own_addr = data;
        else if (idx == ltdf_pkg::CFG_LIFETIME) sb.life_load = data[15:0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    function automatic t_item pkt(logic [2:0] k, logic [47:0] m, logic [31:0] t,
                                  logic [15:0] s);
        t_item it;
        it.req = 0;
        it.kind = k;
        it.mac = m;
        it.ts = t;
        it.sn = s;
        it.lat = $urandom;
        it.lon = $urandom;
        return it;
    endfunction

    function automatic t_item tick();
        t_item it;
        it = '0;
        it.req = 1;
        it.mac = 48'({$urandom, $urandom});
        it.kind = 3'($urandom);
        return it;
    endfunction

    function automatic t_item rand_item(int ticks_pct, int pool);
        t_item it;
        if ($urandom_range(0, 99) < ticks_pct) return tick();
        it = pkt(3'($urandom), macs[$urandom_range(0, pool - 1)], $urandom,
                 16'($urandom));
        case ($urandom_range(0, 5))
            0: it.mac = 48'({$urandom, $urandom});
            1: it.mac = sb.own_addr;
            2, 3: it.ts = {30'h0, 2'($urandom)};
            default: ;
        endcase
        return it;
    endfunction

    task automatic run_phase(int n, int ticks_pct, int pool, bit busy);
        for (int i = 0; i < n; i++)
            send(rand_item(ticks_pct, pool), busy ? 0 : $urandom_range(0, 6));
    endtask

    initial begin
        for (int i = 0; i < 24; i++) macs[i] = 48'({$urandom, $urandom});
        macs[0] = 48'hffffffffffff;
        macs[1] = 48'h000000000001;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: own address 0, wrap cases, kinds, sequence compare, full table
        send(pkt(3'd2, 48'h0, 0, 0), 0);
        for (int k = 0; k < 8; k++) send(pkt(k[2:0], macs[k % 2], 32'hffffffff, 16'hffff), 0);
        send(pkt(3'd2, macs[0], 32'h0, 16'h0), 1);
        send(pkt(3'd2, macs[0], 32'h0, 16'h1), 0);
        send(pkt(3'd2, macs[0], 32'h0, 16'h8001), 0);
        send(pkt(3'd0, macs[0], 32'h0, 16'h5), 0);
        send(pkt(3'd7, macs[0], 32'h80000000, 16'h0), 0);
        send(pkt(3'd7, macs[0], 32'h7fffffff, 16'h0), 0);
        for (int i = 2; i < 19; i++) send(pkt(3'd4, macs[i], 32'(i), 16'(i)), 0);
        for (int i = 0; i < 3; i++) send(tick(), 0);
        drain();

        write_reg(ltdf_pkg::CFG_LOCAL_ADDR, 48'hffffffffffff);
        write_reg(ltdf_pkg::CFG_LIFETIME, 48'd1);
        write_reg(2'd2, 48'h123);
        write_reg(2'd3, 48'h5);
        send(pkt(3'd1, macs[0], 5, 5), 0);
        send(tick(), 0);
        send(tick(), 0);
        drain();

        write_reg(ltdf_pkg::CFG_LIFETIME, 48'd0);
        write_reg(ltdf_pkg::CFG_LOCAL_ADDR, macs[3]);
        run_phase(200, 15, 20, 0);
        drain();

        write_reg(ltdf_pkg::CFG_LIFETIME, 48'hffff);
        write_reg(ltdf_pkg::CFG_LOCAL_ADDR, 48'h0);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            run_phase(300, 5, 24, 1);
        join
        drain();

        write_reg(ltdf_pkg::CFG_LIFETIME, 48'd3);
        write_reg(ltdf_pkg::CFG_LOCAL_ADDR, 48'({$urandom, $urandom}));
        run_phase(450, 25, 12, 0);
        drain();

        write_reg(ltdf_pkg::CFG_LIFETIME, 48'd6);
        run_phase(400, 20, 18, 0);
        drain();

        $display("%0d items sent, %0d results checked", sent, sb.checked);
        $display("new %0d upd %0d dup %0d own %0d full %0d tick %0d",
                 sb.stat_seen[0], sb.stat_seen[1], sb.stat_seen[2],
                 sb.stat_seen[3], sb.stat_seen[4], sb.stat_seen[5]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("location_table_duplicate_filter_tb: clean");
        else
            $display("location_table_duplicate_filter_tb: errors");
        $finish;
    end
endmodule
